@@ src/akd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akd_pkg
// Shared types, constants and helpers for the ADC keypad debouncer.
// ----------------------------------------------------------------------------
package akd_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TICK_BITS       = 8;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int MODE_CODE_BITS  = 2;

    localparam int PRESS_THRESHOLD_RST = 3;
    localparam int TOLERANCE_RST       = 5;
    localparam logic [TICK_BITS-1:0] STABLE_TICKS_RST = 8'd250;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PRESS_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_TICKS    = 2'd2;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_TICK   = 1'b1;

    localparam logic [MODE_CODE_BITS-1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [MODE_CODE_BITS-1:0] MODE_CODE_PEND = 2'd1;
    localparam logic [MODE_CODE_BITS-1:0] MODE_CODE_REL  = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_PEND = 3'b010,
        MODE_REL  = 3'b100
    } mode_t;

    typedef struct packed {
        logic                      accepted;
        logic [MODE_CODE_BITS-1:0] mode_code;
    } akd_status_t;

    function automatic logic [MODE_CODE_BITS-1:0] mode_to_code(input mode_t m);
        logic [MODE_CODE_BITS-1:0] code;
        unique case (m)
            MODE_PEND: code = MODE_CODE_PEND;
            MODE_REL:  code = MODE_CODE_REL;
            default:   code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ src/adc_keypad_debouncer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_keypad_debouncer
// Keypad debouncer on averaged ADC samples and hold-timer ticks.
// Each input transaction passes the input reg, then the result reg.
// Throughput: 1 transaction per cycle while the result side is not stalled;
//   one result per input, set by the state update between input and result registers.
// Reset: async active-low; state idle, timer stopped, registers 3 / 5 / 250.
// ----------------------------------------------------------------------------
module adc_keypad_debouncer
    import akd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [SAMPLE_BITS-1:0] sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    // [0] action
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // press_value, press_code, mode_now (low to high)
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
    // [0] accepted
    output logic                                   m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]              cfg_index,
    input  logic [SAMPLE_BITS-1:0]                 cfg_data
);

    localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;

    logic [SAMPLE_BITS-1:0] press_threshold_reg;
    logic [SAMPLE_BITS-1:0] tolerance_reg;
    logic [TICK_BITS-1:0]   stable_ticks_reg;

    logic                   in_valid_reg;
    logic                   in_action_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    logic                   out_valid_reg, out_valid_next;
    akd_status_t            out_status_reg;
    logic [SAMPLE_BITS-1:0] out_value_reg;
    logic [SAMPLE_BITS-3:0] out_code_reg;

    logic                   pipe_ready;
    logic                   fire;
    akd_status_t            status;
    logic [SAMPLE_BITS-1:0] press_value;
    logic [SAMPLE_BITS-3:0] press_code;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_threshold_reg <= SAMPLE_BITS'(PRESS_THRESHOLD_RST);
            tolerance_reg       <= SAMPLE_BITS'(TOLERANCE_RST);
            stable_ticks_reg    <= STABLE_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_PRESS_THRESHOLD)
                press_threshold_reg <= cfg_data;
            if (cfg_index == REG_TOLERANCE)
                tolerance_reg <= cfg_data;
            if (cfg_index == REG_STABLE_TICKS)
                stable_ticks_reg <= cfg_data[TICK_BITS-1:0];
        end
    end

    assign pipe_ready = !out_valid_reg || m_tready;
    assign fire       = in_valid_reg && pipe_ready;
    assign s_tready   = !in_valid_reg || pipe_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= s_tuser;
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    akd_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .action          (in_action_reg),
        .sample          (in_sample_reg),
        .press_threshold (press_threshold_reg),
        .tolerance       (tolerance_reg),
        .stable_ticks    (stable_ticks_reg),
        .status          (status),
        .press_value     (press_value),
        .press_code      (press_code)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (fire)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg <= status;
            out_value_reg  <= press_value;
            out_code_reg   <= press_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg.accepted;
    assign m_tdata  = OUT_W'({out_status_reg.mode_code, out_code_reg, out_value_reg});

`ifndef ASSERT_OFF
    a_accept_means_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg.accepted |->
            out_status_reg.mode_code == MODE_CODE_REL)
        else $error("accepted result without release-wait mode");

    a_no_accept_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_status_reg.accepted |->
            out_value_reg == '0 && out_code_reg == '0)
        else $error("press value nonzero on unaccepted result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in pipeline");

    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("transaction lost between stages");
`endif

endmodule

@@ src/akd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akd_core
// Debounce state and its update for one sample or tick.
// ----------------------------------------------------------------------------
module akd_core
    import akd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic                   action,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] press_threshold,
    input  logic [SAMPLE_BITS-1:0] tolerance,
    input  logic [TICK_BITS-1:0]   stable_ticks,
    output akd_status_t            status,
    output logic [SAMPLE_BITS-1:0] press_value,
    output logic [SAMPLE_BITS-3:0] press_code
);

    mode_t                  mode_reg, mode_next;
    logic [SAMPLE_BITS-1:0] reference_reg, reference_next;
    logic [TICK_BITS-1:0]   tick_count_reg, tick_count_next;
    logic                   timer_running_reg, timer_running_next;
    logic                   hold_expired_reg, hold_expired_next;

    logic [SAMPLE_BITS-1:0] diff;
    logic                   acc;

    assign diff = (reference_reg > sample) ? (reference_reg - sample)
                                           : (sample - reference_reg);

    always_comb
    begin
        mode_next          = mode_reg;
        reference_next     = reference_reg;
        tick_count_next    = tick_count_reg;
        timer_running_next = timer_running_reg;
        hold_expired_next  = hold_expired_reg;
        acc                = 1'b0;
        if (action == ACTION_TICK)
        begin
            if (timer_running_reg)
            begin
                if (tick_count_reg == stable_ticks)
                begin
                    hold_expired_next  = 1'b1;
                    timer_running_next = 1'b0;
                    tick_count_next    = '0;
                end
                else
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_PEND:
                begin
                    if (diff > tolerance)
                    begin
                        reference_next     = sample;
                        tick_count_next    = '0;
                        timer_running_next = 1'b1;
                        hold_expired_next  = 1'b0;
                    end
                    else if (hold_expired_reg)
                    begin
                        acc       = 1'b1;
                        mode_next = MODE_REL;
                    end
                end
                MODE_REL:
                begin
                    if (sample <= press_threshold)
                        mode_next = MODE_IDLE;
                end
                default:
                begin
                    mode_next      = MODE_IDLE;
                    reference_next = sample;
                    if (sample > press_threshold)
                    begin
                        mode_next          = MODE_PEND;
                        tick_count_next    = '0;
                        timer_running_next = 1'b1;
                        hold_expired_next  = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            reference_reg     <= '0;
            tick_count_reg    <= '0;
            timer_running_reg <= 1'b0;
            hold_expired_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg          <= mode_next;
            reference_reg     <= reference_next;
            tick_count_reg    <= tick_count_next;
            timer_running_reg <= timer_running_next;
            hold_expired_reg  <= hold_expired_next;
        end
    end

    assign status.accepted  = acc;
    assign status.mode_code = mode_to_code(mode_next);
    assign press_value      = acc ? sample : '0;
    assign press_code       = acc ? sample[SAMPLE_BITS-1:2] : '0;

endmodule

@@ sim/akd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akd_checker
// Watches the sample/tick, result and register channels of the keypad
// debouncer. Tracks the register values and the debounce state on its own,
// predicts one report per accepted sample or tick, and compares each result
// transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module akd_checker
    import akd_pkg::*;
#(
    parameter int SB = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [((SB+7)/8)*8-1:0]       s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [((2*SB+7)/8)*8-1:0]     m_tdata,
    input  logic                          m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [SB-1:0]                 cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            results_seen,
    output int                            presses_seen
);

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic                      accepted;
        logic [SB-1:0]             value;
        logic [SB-3:0]             code;
        logic [MODE_CODE_BITS-1:0] mode;
    } keypad_report_t;

    logic [SB-1:0]             thr_reg;
    logic [SB-1:0]             tol_reg;
    logic [TICK_BITS-1:0]      hold_reg;

    logic [MODE_CODE_BITS-1:0] db_mode;
    logic [SB-1:0]             db_ref;
    logic [TICK_BITS-1:0]      db_ticks;
    logic                      db_running;
    logic                      db_expired;

    keypad_report_t            keypad_reports_q[$];
    int                        errors;
    int                        n_results;
    int                        n_presses;

    function automatic keypad_report_t debounce_step(input logic act,
                                                     input logic [SB-1:0] smp);
        keypad_report_t r;
        logic [SB-1:0]  spread;
        r = '0;
        if (act == ACTION_TICK) begin
            if (db_running) begin
                if (db_ticks == hold_reg) begin
                    db_expired = 1'b1;
                    db_running = 1'b0;
                    db_ticks   = '0;
                end else begin
                    db_ticks = db_ticks + 1'b1;
                end
            end
        end else if (db_mode == MODE_CODE_PEND) begin
            spread = (db_ref > smp) ? db_ref - smp : smp - db_ref;
            if (spread > tol_reg) begin
                // bounce: new reference, hold timer starts over
                db_ref     = smp;
                db_ticks   = '0;
                db_running = 1'b1;
                db_expired = 1'b0;
            end else if (db_expired) begin
                r.accepted = 1'b1;
                r.value    = smp;
                r.code     = smp[SB-1:2];
                db_mode    = MODE_CODE_REL;
            end
        end else if (db_mode == MODE_CODE_REL) begin
            if (smp <= thr_reg)
                db_mode = MODE_CODE_IDLE;
        end else begin
            db_mode = MODE_CODE_IDLE;
            db_ref  = smp;
            if (smp > thr_reg) begin
                db_mode    = MODE_CODE_PEND;
                db_ticks   = '0;
                db_running = 1'b1;
                db_expired = 1'b0;
            end
        end
        r.mode = db_mode;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        keypad_report_t want;
        keypad_report_t got;
        if (!rst_n)
        begin
            thr_reg    = SB'(PRESS_THRESHOLD_RST);
            tol_reg    = SB'(TOLERANCE_RST);
            hold_reg   = STABLE_TICKS_RST;
            db_mode    = MODE_CODE_IDLE;
            db_ref     = '0;
            db_ticks   = '0;
            db_running = 1'b0;
            db_expired = 1'b0;
            keypad_reports_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PRESS_THRESHOLD: thr_reg  = cfg_data;
                    REG_TOLERANCE:       tol_reg  = cfg_data;
                    REG_STABLE_TICKS:    hold_reg = cfg_data[TICK_BITS-1:0];
                    default:             ;
                endcase
            end
            if (s_tvalid && s_tready)
                keypad_reports_q.push_back(debounce_step(s_tuser, s_tdata[SB-1:0]));
            if (m_tvalid && m_tready)
            begin
                got.accepted = m_tuser;
                got.value    = m_tdata[SB-1:0];
                got.code     = m_tdata[2*SB-3:SB];
                got.mode     = m_tdata[2*SB-1:2*SB-2];
                n_results++;
                if (got.accepted)
                    n_presses++;
                if (keypad_reports_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("%0t: result with nothing outstanding: tuser %b tdata %h",
                                 $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = keypad_reports_q.pop_front();
                    if (got.accepted !== want.accepted || got.value !== want.value ||
                        got.code !== want.code || got.mode !== want.mode)
                    begin
                        errors++;
                        if (errors <= MAX_SHOWN)
                            $display(
                                "%0t: exp/act acc %b/%b val %0d/%0d code %0d/%0d mode %0d/%0d",
                                $time, want.accepted, got.accepted, want.value,
                                got.value, want.code, got.code, want.mode, got.mode);
                    end
                end
            end
        end
        fail_count   <= errors;
        pending      <= keypad_reports_q.size();
        results_seen <= n_results;
        presses_seen <= n_presses;
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the ADC keypad debouncer. A directed opener hits
// the threshold, tolerance and hold-timer corner cases; random phases then
// run press/bounce/release sequences with tick streams under changing
// register settings, bursty input and a stalling result side. Checking is
// done by akd_checker.
// ----------------------------------------------------------------------------
module testbench;
    import akd_pkg::*;

    localparam int SB            = SAMPLE_BITS_DEF;
    localparam int SD_W          = ((SB+7)/8)*8;
    localparam int MD_W          = ((2*SB+7)/8)*8;
    localparam int SAMPLE_TOP    = (1 << SB) - 1;
    localparam int ITEM_TARGET   = 1150;
    localparam int PHASE_ITEMS   = 90;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 4000;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [SD_W-1:0]           s_tdata   = '0;     // [SB-1:0] sample
    logic                      s_tuser   = 1'b0;   // [0] action
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [MD_W-1:0]           m_tdata;            // press_value, press_code, mode_now
    logic                      m_tuser;            // [0] accepted
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [SB-1:0]             cfg_data  = '0;

    int fail_count;
    int pending;
    int results_seen;
    int presses_seen;

    int items_sent    = 0;
    int cfg_writes    = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    bit steady        = 1'b0;
    int cur_thr       = PRESS_THRESHOLD_RST;
    int cur_tol       = TOLERANCE_RST;
    int cur_stab      = STABLE_TICKS_RST;

    adc_keypad_debouncer #(.SAMPLE_BITS(SB)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    akd_checker #(.SB(SB)) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .presses_seen (presses_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side: random stall styles, plus a long hold on request
    initial
    begin : rx_side
        int style;
        int seg;
        int k;
        int hold_seen;
        hold_seen = 0;
        forever
        begin
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                m_tready <= 1'b0;
                for (k = 0; k < LONG_HOLD; k++)
                    @(posedge clk);
            end
            else
            begin
                style = $urandom_range(0, 3);
                seg   = $urandom_range(10, 120);
                for (k = 0; k < seg && hold_requests == hold_seen; k++)
                begin
                    case (style)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 1) == 1);
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= (k % 4 != 3);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic offer(input logic act, input int smp);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 :
                  ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(SD_W-SB){1'b0}}, smp[SB-1:0]};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[SB-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic apply_settings(input int thr, input int tol, input int stab);
        settle();
        cur_thr  = thr;
        cur_tol  = tol;
        cur_stab = stab;
        write_reg(REG_PRESS_THRESHOLD, thr);
        write_reg(REG_TOLERANCE, tol);
        // bits above the tick width are don't-care for the hold count
        write_reg(REG_STABLE_TICKS, (int'($urandom_range(0, 3)) << TICK_BITS) | stab);
    endtask

    function automatic int near_key(input int centre, input int half);
        int v;
        v = int'($urandom_range(0, 2 * half));
        v = centre + v - half;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_TOP)
            v = SAMPLE_TOP;
        return v;
    endfunction

    function automatic int below_thr();
        return $urandom_range(0, cur_thr);
    endfunction

    task automatic tick();
        offer(ACTION_TICK, $urandom_range(0, SAMPLE_TOP));
    endtask

    // idle chatter, press, bouncing hold with ticks, then confirm and release or abandon
    task automatic press_episode();
        int  key;
        int  half;
        int  n;
        int  k;
        bit  bounced;
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 1) == 0)
                tick();
            else
                offer(ACTION_SAMPLE, below_thr());
        end
        key  = (cur_thr >= SAMPLE_TOP) ? $urandom_range(0, SAMPLE_TOP)
                                       : $urandom_range(cur_thr + 1, SAMPLE_TOP);
        half = cur_tol / 2;
        offer(ACTION_SAMPLE, key);
        bounced = 1'b0;
        n = cur_stab + 1 + $urandom_range(0, 2);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                offer(ACTION_SAMPLE, near_key(key, half));
            if (!bounced && $urandom_range(0, 19) == 0)
            begin
                bounced = 1'b1;
                key     = $urandom_range(0, SAMPLE_TOP);
                offer(ACTION_SAMPLE, key);
                k = 0;
            end
            tick();
        end
        if ($urandom_range(0, 5) == 0)
        begin
            // abandoned before confirmation
            offer(ACTION_SAMPLE, below_thr());
        end
        else
        begin
            offer(ACTION_SAMPLE, near_key(key, half));
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                    tick();
                else
                    offer(ACTION_SAMPLE, near_key(key, half));
            end
            offer(ACTION_SAMPLE, below_thr());
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_start;
        int pick;
        int thr;
        int tol;
        int stab;
        int k;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: threshold 3, tolerance 5, hold 250
        tick();
        offer(ACTION_SAMPLE, 0);
        offer(ACTION_SAMPLE, 3);
        offer(ACTION_SAMPLE, 4);
        tick();
        offer(ACTION_SAMPLE, SAMPLE_TOP);
        offer(ACTION_SAMPLE, SAMPLE_TOP - 5);

        settle();
        write_reg(REG_UNUSED, $urandom_range(0, SAMPLE_TOP));
        apply_settings(100, 0, 0);
        tick();
        tick();
        offer(ACTION_SAMPLE, SAMPLE_TOP);
        offer(ACTION_SAMPLE, 101);
        offer(ACTION_SAMPLE, 100);
        offer(ACTION_SAMPLE, 101);
        tick();
        offer(ACTION_SAMPLE, 0);
        offer(ACTION_SAMPLE, 0);
        tick();
        offer(ACTION_SAMPLE, 0);
        offer(ACTION_SAMPLE, 0);

        for (phase = 0; items_sent < ITEM_TARGET; phase++)
        begin
            pick = $urandom_range(0, 9);
            thr  = (pick == 0) ? 0 :
                   (pick < 4)  ? $urandom_range(0, SAMPLE_TOP) : $urandom_range(10, 500);
            pick = $urandom_range(0, 9);
            tol  = (pick == 0) ? 0 :
                   (pick == 1) ? SAMPLE_TOP :
                   (pick < 4)  ? $urandom_range(0, SAMPLE_TOP) : $urandom_range(1, 30);
            pick = $urandom_range(0, 9);
            stab = (pick == 0) ? 0 :
                   (pick == 1) ? $urandom_range(10, 40) : $urandom_range(0, 6);
            steady = 1'b0;
            case (phase)
                0:       stab = 255;
                1:
                begin
                    thr    = 0;
                    tol    = 0;
                    steady = 1'b1;
                end
                2:
                begin
                    thr  = 100;
                    tol  = 0;
                    stab = 255;
                end
                3:
                begin
                    thr = SAMPLE_TOP;
                    tol = SAMPLE_TOP;
                end
                default: ;
            endcase
            apply_settings(thr, tol, stab);
            phase_start = items_sent;
            if (phase == 1)
                hold_requests <= hold_requests + 1;

            if (phase == 2)
            begin
                // tick count runs past a lowered hold value and wraps
                for (k = 0; k < 3; k++)
                    offer(ACTION_SAMPLE, 0);
                offer(ACTION_SAMPLE, 700);
                for (k = 0; k < 150; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        offer(ACTION_SAMPLE, 700);
                    tick();
                end
                apply_settings(100, 0, 20);
                for (k = 0; k < 130; k++)
                    tick();
                offer(ACTION_SAMPLE, 700);
                offer(ACTION_SAMPLE, 0);
            end
            else
            begin
                while (items_sent - phase_start < PHASE_ITEMS)
                begin
                    if ($urandom_range(0, 6) == 0)
                    begin
                        pick = $urandom_range(1, 5);
                        for (k = 0; k < pick; k++)
                            offer(1'($urandom_range(0, 1)), $urandom_range(0, SAMPLE_TOP));
                    end
                    else
                    begin
                        press_episode();
                    end
                end
            end
        end

        settle();
        $display("Covered %0d sample/tick transactions, %0d results, %0d confirmed presses,",
                 items_sent, results_seen, presses_seen);
        $display("  %0d register writes incl. threshold/tolerance/hold extremes and tick wrap",
                 cfg_writes);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
